// File: src/psd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants for the position stall detector.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned PosW     = 16;
  localparam int unsigned SqW      = 2 * PosW;
  localparam int unsigned RadW     = 2 * SqW - 2 * (SqW - PosW) + 2;   // 34 bit radicand
  localparam int unsigned DistW    = 17;
  localparam int unsigned RemW     = DistW + 2;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned RootSteps = RadW / 2;
  localparam int unsigned StepW    = $clog2(RootSteps);

  localparam logic [CfgIdxW-1:0] RegXLimit     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegYLimit     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegCountLimit = 2'd3;

  localparam logic [PosW-1:0]   XLimitReset     = 16'd49152;
  localparam logic [PosW-1:0]   YLimitReset     = 16'd61440;
  localparam logic [DistW-1:0]  ThresholdReset  = 17'd41;
  localparam logic [CountW-1:0] CountLimitReset = 8'd1;
  localparam logic [CountW-1:0] StillCountMax   = 8'd255;

  // one queued sample: range flag and the two squares
  typedef struct packed {
    logic            in_range;
    logic [SqW-1:0]  sq_x;
    logic [SqW-1:0]  sq_y;
  } psd_job_t;

endpackage

// File: src/psd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_front
// Accepts position samples, checks them against the box and squares x and y.
// ----------------------------------------------------------------------------
module psd_front
  import psd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [PosW-1:0] pos_x_i,
  input  logic [PosW-1:0] pos_y_i,
  input  logic [PosW-1:0] x_limit_i,
  input  logic [PosW-1:0] y_limit_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output psd_job_t        q_data_o
);

  logic            s1_v_q, s1_v_d;
  logic [PosW-1:0] s1_x_q, s1_y_q;
  logic            s1_rng_q;
  logic            s2_v_q, s2_v_d;
  psd_job_t        s2_q;
  logic            s1_ready, s2_ready, in_acc, rng;

  assign rng = (pos_x_i != '0) && (pos_x_i < x_limit_i) &&
               (pos_y_i != '0) && (pos_y_i < y_limit_i);

  assign q_push_o   = s2_v_q && !q_full_i;
  assign s2_ready   = !s2_v_q || !q_full_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;
  assign q_data_o   = s2_q;

  always_comb begin
    s1_v_d = s1_v_q;
    s2_v_d = s2_v_q;
    if (s1_ready) begin
      s1_v_d = in_valid_i;
    end
    if (s2_ready) begin
      s2_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q   <= pos_x_i;
      s1_y_q   <= pos_y_i;
      s1_rng_q <= rng;
    end
    if (s2_ready && s1_v_q) begin
      s2_q.in_range <= s1_rng_q;
      s2_q.sq_x     <= SqW'(s1_x_q) * SqW'(s1_x_q);
      s2_q.sq_y     <= SqW'(s1_y_q) * SqW'(s1_y_q);
    end
  end

endmodule

// File: src/psd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_fifo
// Short queue of squared samples between the front and the back.
// ----------------------------------------------------------------------------
module psd_fifo
  import psd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  psd_job_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output psd_job_t rdata_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  psd_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// File: src/psd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_back
// Square root of the squared distance, stall counting and the result word.
// ----------------------------------------------------------------------------
module psd_back
  import psd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  psd_job_t          q_data_i,
  output logic              q_pop_o,
  input  logic [DistW-1:0]  threshold_i,
  input  logic [CountW-1:0] count_limit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              reverse_request_o,
  output logic              sample_in_range_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StDiff = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]        st_q, st_d;
  logic [RadW-1:0]   val_q, val_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DistW-1:0]  root_q, root_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DistW-1:0]  diff_q, diff_d;
  logic [DistW-1:0]  prev_q, prev_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_v_q, out_v_d;
  logic              out_rev_q, out_rev_d;
  logic              out_rng_q, out_rng_d;
  logic              out_free;
  logic [RemW+1:0]   rem_t;
  logic [RemW+2:0]   trial;
  logic [CountW-1:0] cnt_new;

  assign out_free          = !out_v_q || !out_stall_i;
  assign out_valid_o       = out_v_q;
  assign reverse_request_o = out_rev_q;
  assign sample_in_range_o = out_rng_q;

  // one result bit per step: bring down two radicand bits, try subtracting 4*root+1
  assign rem_t = {rem_q, val_q[RadW-1 -: 2]};
  assign trial = {1'b0, rem_t} - {3'b000, root_q, 2'b01};

  always_comb begin
    if (diff_q <= threshold_i) begin
      cnt_new = (cnt_q == StillCountMax) ? cnt_q : cnt_q + CountW'(1);
    end else begin
      cnt_new = '0;
    end
  end

  always_comb begin
    st_d      = st_q;
    val_d     = val_q;
    rem_d     = rem_q;
    root_d    = root_q;
    step_d    = step_q;
    diff_d    = diff_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    out_v_d   = out_v_q && out_stall_i;
    out_rev_d = out_rev_q;
    out_rng_d = out_rng_q;
    q_pop_o   = 1'b0;
    case (st_q)
      StIdle: begin
        if (!q_empty_i) begin
          if (q_data_i.in_range) begin
            q_pop_o = 1'b1;
            val_d   = RadW'({1'b0, q_data_i.sq_x} + {1'b0, q_data_i.sq_y});
            rem_d   = '0;
            root_d  = '0;
            step_d  = StepW'(RootSteps - 1);
            st_d    = StRoot;
          end else if (out_free) begin
            // sample outside the box: state untouched
            q_pop_o   = 1'b1;
            out_v_d   = 1'b1;
            out_rev_d = 1'b0;
            out_rng_d = 1'b0;
          end
        end
      end
      StRoot: begin
        val_d = {val_q[RadW-3:0], 2'b00};
        if (!trial[RemW+2]) begin
          rem_d  = trial[RemW-1:0];
          root_d = {root_q[DistW-2:0], 1'b1};
        end else begin
          rem_d  = rem_t[RemW-1:0];
          root_d = {root_q[DistW-2:0], 1'b0};
        end
        step_d = step_q - StepW'(1);
        if (step_q == '0) begin
          st_d = StDiff;
        end
      end
      StDiff: begin
        diff_d = (root_q >= prev_q) ? root_q - prev_q : prev_q - root_q;
        st_d   = StDone;
      end
      StDone: begin
        if (out_free) begin
          cnt_d     = cnt_new;
          prev_d    = root_q;
          out_v_d   = 1'b1;
          out_rev_d = (cnt_new >= count_limit_i);
          out_rng_d = 1'b1;
          st_d      = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      prev_q  <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    step_q    <= step_d;
    diff_q    <= diff_d;
    out_rev_q <= out_rev_d;
    out_rng_q <= out_rng_d;
  end

endmodule

// File: src/position_stall_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_stall_detector
// Flags a stalled vehicle from a stream of x,y position samples.
// ----------------------------------------------------------------------------
// Each word in carries one x,y sample (unsigned Q4.12 m) and gives exactly one
// word out. A sample is used only when 0 < x < x_limit and 0 < y < y_limit;
// otherwise it comes back with sample_in_range = 0 and reverse_request = 0 and
// changes nothing. For a used sample the distance from the origin is
// floor(sqrt(x*x + y*y)) in Q5.12; when it moved by at most still_threshold
// since the last used sample a saturating still counter steps, else it
// clears, and reverse_request is set once the counter reaches
// still_count_limit. A used sample holds the back end through the
// bit-per-cycle square root, which sets the rate, then a difference and an
// output step; an unused one goes straight out. The front end squares x and
// y in two registered stages and a short queue lets it take further samples
// while a root is in progress. Configuration registers: 0 x_limit, 1 y_limit,
// 2 still_threshold, 3 still_count_limit; write them only while idle.
// ----------------------------------------------------------------------------
module position_stall_detector
  import psd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PosW-1:0]     pos_x_i,
  input  logic [PosW-1:0]     pos_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                reverse_request_o,
  output logic                sample_in_range_o
);

  logic [PosW-1:0]   x_limit_q, y_limit_q;
  logic [DistW-1:0]  threshold_q;
  logic [CountW-1:0] count_limit_q;
  logic              q_push, q_pop, q_full, q_empty;
  psd_job_t          q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q     <= XLimitReset;
      y_limit_q     <= YLimitReset;
      threshold_q   <= ThresholdReset;
      count_limit_q <= CountLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegXLimit:     x_limit_q     <= cfg_wdata_i[PosW-1:0];
        RegYLimit:     y_limit_q     <= cfg_wdata_i[PosW-1:0];
        RegThreshold:  threshold_q   <= cfg_wdata_i[DistW-1:0];
        RegCountLimit: count_limit_q <= cfg_wdata_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  psd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .x_limit_i  (x_limit_q),
    .y_limit_i  (y_limit_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  psd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  psd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .threshold_i       (threshold_q),
    .count_limit_i     (count_limit_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reverse_request_o (reverse_request_o),
    .sample_in_range_o (sample_in_range_o)
  );

  // an unused sample never asks for reverse
  a_no_reverse_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_in_range_o |-> !reverse_request_o)
    else $error("reverse requested for a sample outside the box");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("front pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("back popped an empty queue");

endmodule

// File: test/tb_position_stall_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_position_stall_detector
// Self-checking bench for the position stall detector. Samples are driven
// through the valid/stall handshake with random gaps on both sides; a
// bit-accurate predictor (box test, floor root of x^2+y^2, saturating still
// counter) gives the expected word for every accepted sample, and a checker
// compares each word out with the oldest expectation. Covers the reset
// configuration, box corners, zero limits, counter saturation and random
// walks under several register settings.
// ----------------------------------------------------------------------------
module tb_position_stall_detector;
  import psd_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainWait = 30;

  typedef struct packed {
    logic reverse;
    logic in_range;
  } verdict_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PosW-1:0]     pos_x_i     = '0;
  logic [PosW-1:0]     pos_y_i     = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                reverse_request_o;
  logic                sample_in_range_o;

  // predictor copy of registers and state
  logic [PosW-1:0]   lim_x        = XLimitReset;
  logic [PosW-1:0]   lim_y        = YLimitReset;
  logic [DistW-1:0]  still_thr    = ThresholdReset;
  logic [CountW-1:0] still_needed = CountLimitReset;
  logic [DistW-1:0]  last_dist    = '0;
  logic [CountW-1:0] still_run    = '0;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          gaps_on        = 1'b1;

  position_stall_detector uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reverse_request_o (reverse_request_o),
    .sample_in_range_o (sample_in_range_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [DistW-1:0] floor_root(input logic [33:0] v);
    logic [DistW-1:0] r;
    logic [DistW-1:0] t;
    r = '0;
    for (int b = DistW - 1; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (34'(t) * 34'(t) <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  // updates the predicted state and returns the word the block should give
  function automatic verdict_t judge_sample(input logic [PosW-1:0] x, input logic [PosW-1:0] y);
    logic [33:0]      radicand;
    logic [DistW-1:0] radius;
    logic [DistW-1:0] diff;
    verdict_t         v;
    v = '0;
    if (x == '0 || x >= lim_x || y == '0 || y >= lim_y) begin
      return v;
    end
    radicand = 34'(x) * 34'(x) + 34'(y) * 34'(y);
    radius = floor_root(radicand);
    diff = (radius >= last_dist) ? radius - last_dist : last_dist - radius;
    if (diff <= still_thr) begin
      if (still_run != StillCountMax) begin
        still_run = still_run + CountW'(1);
      end
    end else begin
      still_run = '0;
    end
    last_dist  = radius;
    v.reverse  = (still_run >= still_needed);
    v.in_range = 1'b1;
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // receiver side: random stall, checked at the rising edge
  always @(negedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin : check_words
    verdict_t want;
    bit       got_in;
    bit       got_out;
    got_in  = rst_ni && in_valid_i && !in_stall_o;
    got_out = rst_ni && out_valid_o && !out_stall_i;
    if (got_out) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("word out with nothing expected");
      end else begin
        want = pending_verdicts.pop_front();
        if (sample_in_range_o !== want.in_range) begin
          report_mismatch($sformatf("sample_in_range %b, expected %b",
                                    sample_in_range_o, want.in_range));
        end
        if (reverse_request_o !== want.reverse) begin
          report_mismatch($sformatf("reverse_request %b, expected %b",
                                    reverse_request_o, want.reverse));
        end
      end
    end
    if (got_in || got_out) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_position_stall_detector: done, errors");
        $finish;
      end
    end
  end

  task automatic send_sample(input logic [PosW-1:0] x, input logic [PosW-1:0] y);
    @(negedge clk_i);
    while (gaps_on && ($urandom_range(99) < 35)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(judge_sample(x, y));
  endtask

  // drop valid and wait until every word has come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegXLimit:     lim_x        = val[PosW-1:0];
      RegYLimit:     lim_y        = val[PosW-1:0];
      RegThreshold:  still_thr    = val;
      RegCountLimit: still_needed = val[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [PosW-1:0] xl, input logic [PosW-1:0] yl,
                           input logic [DistW-1:0] thr, input logic [CountW-1:0] cnt);
    settle();
    write_reg(RegXLimit, CfgDataW'(xl));
    write_reg(RegYLimit, CfgDataW'(yl));
    write_reg(RegThreshold, thr);
    write_reg(RegCountLimit, CfgDataW'(cnt));
  endtask

  // reset limits, first sample compared against zero, box edges
  task automatic test_reset_defaults();
    send_sample(16'd1, 16'd1);
    send_sample(16'd1, 16'd1);
    send_sample(16'd49151, 16'd1);
    send_sample(16'd49152, 16'd1);
    send_sample(16'd1, 16'd61439);
    send_sample(16'd1, 16'd61440);
    send_sample(16'd0, 16'd100);
    send_sample(16'd100, 16'd0);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'd49151, 16'd61439);
    send_sample(16'd49151, 16'd61439);
  endtask

  // widest box, zero threshold, zero count limit
  task automatic test_box_corners();
    configure(16'hFFFF, 16'hFFFF, '0, '0);
    send_sample(16'hFFFE, 16'hFFFE);
    send_sample(16'hFFFE, 16'hFFFE);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFE);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
  endtask

  task automatic test_zero_limits();
    configure(16'd0, 16'hFFFF, ThresholdReset, CountLimitReset);
    send_sample(16'd1, 16'd1);
    send_sample(16'hFFFF, 16'd7);
    configure(16'hFFFF, 16'd0, ThresholdReset, CountLimitReset);
    send_sample(16'd1, 16'd1);
    send_sample(16'd9, 16'hFFFF);
  endtask

  // every move counts as still, so the counter runs into its ceiling
  task automatic test_counter_saturation();
    configure(XLimitReset, YLimitReset, 17'h1FFFF, StillCountMax);
    for (int i = 0; i < 262; i++) begin
      send_sample(16'($urandom_range(1, XLimitReset - 1)),
                  16'($urandom_range(1, YLimitReset - 1)));
    end
  endtask

  function automatic logic [PosW-1:0] step_coord(input logic [PosW-1:0] c,
                                                 input logic [PosW-1:0] lim,
                                                 input int unsigned step_max);
    int v;
    v = int'(c) + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(step_max));
    if (v < 1) v = 1;
    if (v > int'(lim) - 1) v = int'(lim) - 1;
    return PosW'(v);
  endfunction

  // random walks: mostly small moves that build up the still count,
  // some jumps, and some noise outside or on the box edge
  task automatic test_random_walks();
    logic [PosW-1:0]  xl;
    logic [PosW-1:0]  yl;
    logic [DistW-1:0] thr;
    logic [CountW-1:0] cnt;
    logic [PosW-1:0]  cx;
    logic [PosW-1:0]  cy;
    int unsigned      step_max;
    int unsigned      pick;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin xl = 16'hFFFF; yl = 16'hFFFF; end
        1: begin xl = 16'($urandom_range(2, 16)); yl = 16'($urandom_range(2, 16)); end
        default: begin
          xl = 16'($urandom_range(16'h1000, 16'hFFFF));
          yl = 16'($urandom_range(16'h1000, 16'hFFFF));
        end
      endcase
      pick = $urandom_range(9);
      thr  = (pick == 0) ? 17'd0 : (pick == 1) ? 17'h1FFFF : 17'($urandom_range(1, 200));
      cnt  = (phase == 3) ? StillCountMax : 8'($urandom_range(0, 6));
      configure(xl, yl, thr, cnt);
      gaps_on  = (phase != 2);
      step_max = (thr / 2 > 2000) ? 2000 : thr / 2;
      cx = 16'($urandom_range(1, xl - 1));
      cy = 16'($urandom_range(1, yl - 1));
      for (int i = 0; i < 150; i++) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          cx = step_coord(cx, xl, step_max);
          cy = step_coord(cy, yl, step_max);
          send_sample(cx, cy);
        end else if (pick < 84) begin
          cx = 16'($urandom_range(1, xl - 1));
          cy = 16'($urandom_range(1, yl - 1));
          send_sample(cx, cy);
        end else if (pick < 92) begin
          send_sample(16'($urandom), 16'($urandom));
        end else begin
          case ($urandom_range(3))
            0: send_sample(16'd0, cy);
            1: send_sample(cx, 16'd0);
            2: send_sample(xl, cy);
            default: send_sample(cx, yl);
          endcase
        end
      end
      gaps_on = 1'b1;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_box_corners();
    test_zero_limits();
    test_counter_saturation();
    test_random_walks();

    settle();
    if (mismatch_count == 0) begin
      $display("tb_position_stall_detector: done, clean");
    end else begin
      $display("tb_position_stall_detector: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/psd_pkg.sv
src/psd_front.sv
src/psd_fifo.sv
src/psd_back.sv
src/position_stall_detector.sv
test/tb_position_stall_detector.sv
